// ----- sv/emw_pkg.sv -----
package emw_pkg;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned ROW_W   = 12;
    localparam int unsigned COL_W   = 4;
    localparam int unsigned LIK_W   = 32;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned NROWS_W = 13;
    localparam int unsigned NCLS_W  = 5;
    localparam int unsigned ITER_W  = 10;
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned SUM_W   = 36;
    localparam int unsigned CSUM_W  = 48;
    localparam int unsigned NUM_W   = 64;
    localparam int unsigned NSLOT   = 16;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic KIND_WEIGHT    = 1'b0;
    localparam logic KIND_POSTERIOR = 1'b1;

    localparam logic [1:0] REG_NUM_ROWS    = 2'd0;
    localparam logic [1:0] REG_NUM_CLASSES = 2'd1;
    localparam logic [1:0] REG_ITERATIONS  = 2'd2;

    typedef struct packed {
        logic [NROWS_W-1:0] num_rows;
        logic [NCLS_W-1:0]  num_classes;
        logic [ITER_W-1:0]  iterations;
    } t_cfg;

endpackage

// ----- sv/emw_if.sv -----
interface emw_in_if;
    logic                            valid;
    logic                            ready;
    logic [emw_pkg::OP_W-1:0]        op;
    logic [emw_pkg::ROW_W-1:0]       row_addr;
    logic [emw_pkg::COL_W-1:0]       col_index;
    logic [emw_pkg::LIK_W-1:0]       likelihood;

    modport source (output valid, op, row_addr, col_index, likelihood, input ready);
    modport sink   (input valid, op, row_addr, col_index, likelihood, output ready);
endinterface

interface emw_out_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [emw_pkg::COL_W-1:0]       index;
    logic [emw_pkg::VAL_W-1:0]       value;
    logic                            zero_row_seen;
    logic                            last;

    modport source (output valid, kind, index, value, zero_row_seen, last, input ready);
    modport sink   (input valid, kind, index, value, zero_row_seen, last, output ready);
endinterface

// ----- sv/em_mixture_weight_estimation_top.sv -----
// load transaction: accepted one per cycle back to back while the block is idle
// run transaction: K results once the estimation is done; it uses the shared 32-step divider
//   and one likelihood memory read per element
// read transaction: K results, one per cycle while the receiver is ready
// reset clears control state and config (all registers to 1); matrix memories are not cleared
module em_mixture_weight_estimation_top #(
    parameter int unsigned MAX_ROWS    = 4096,
    parameter int unsigned MAX_CLASSES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    emw_in_if.sink                          i_in,
    emw_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [emw_pkg::PADDR_W-1:0]     paddr,
    input  logic [emw_pkg::PDATA_W-1:0]     pwdata,
    output logic [emw_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned CW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int unsigned RCW   = $clog2(MAX_ROWS + 1);
    localparam int unsigned AW    = RW + CW;
    localparam int unsigned DEPTH = 2 ** AW;
    localparam int unsigned CLS   = (MAX_CLASSES < 16) ? MAX_CLASSES : 16;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INIT    = 4'd1;
    localparam logic [3:0] S_E_START = 4'd2;
    localparam logic [3:0] S_E_RD    = 4'd3;
    localparam logic [3:0] S_E_MUL   = 4'd4;
    localparam logic [3:0] S_E_ACC   = 4'd5;
    localparam logic [3:0] S_E_DIV   = 4'd6;
    localparam logic [3:0] S_E_DIVW  = 4'd7;
    localparam logic [3:0] S_M       = 4'd8;
    localparam logic [3:0] S_MW      = 4'd9;
    localparam logic [3:0] S_EMIT_W  = 4'd10;
    localparam logic [3:0] S_RD_RQ   = 4'd11;
    localparam logic [3:0] S_RD_DAT  = 4'd12;
    localparam logic [3:0] S_RD_EMIT = 4'd13;

    emw_pkg::t_cfg cfg;

    logic [3:0]                      r_state;
    logic [RW-1:0]                   r_row;
    logic [emw_pkg::COL_W-1:0]       r_col;
    logic [emw_pkg::ITER_W-1:0]      r_iter;
    logic [emw_pkg::SUM_W-1:0]       r_sum;
    logic [63:0]                     r_mul;
    logic [emw_pkg::VAL_W-1:0]       r_w    [emw_pkg::NSLOT];
    logic [emw_pkg::VAL_W-1:0]       r_pbuf [emw_pkg::NSLOT];
    logic [emw_pkg::CSUM_W-1:0]      r_csum [emw_pkg::NSLOT];
    logic                            r_flag;
    logic                            r_allzero;

    logic                            r_ov;
    logic                            r_kind;
    logic [emw_pkg::COL_W-1:0]       r_index;
    logic [emw_pkg::VAL_W-1:0]       r_value;
    logic                            r_zrs;
    logic                            r_last;

    logic                            in_acc;
    logic                            out_free;
    logic [RCW-1:0]                  rows_used;
    logic [RW-1:0]                   last_row;
    logic [emw_pkg::NCLS_W-1:0]      k_used;
    logic [emw_pkg::COL_W-1:0]       k_last;
    logic                            col_end;

    logic                            lik_we;
    logic [AW-1:0]                   lik_waddr;
    logic [AW-1:0]                   cur_addr;
    logic [emw_pkg::LIK_W-1:0]       lik_rdata;
    logic                            pst_we;
    logic [emw_pkg::VAL_W-1:0]       pst_wdata;
    logic [emw_pkg::VAL_W-1:0]       pst_rdata;

    logic                            div_start;
    logic [emw_pkg::NUM_W-1:0]       div_num;
    logic [emw_pkg::SUM_W-1:0]       div_den;
    logic                            div_done;
    logic [emw_pkg::VAL_W-1:0]       div_q;

    emw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    always_comb begin
        if (cfg.num_rows == '0) begin
            rows_used = RCW'(1);
        end else if (32'(cfg.num_rows) > MAX_ROWS) begin
            rows_used = RCW'(MAX_ROWS);
        end else begin
            rows_used = RCW'(cfg.num_rows);
        end
        if (cfg.num_classes == '0) begin
            k_used = emw_pkg::NCLS_W'(1);
        end else if (32'(cfg.num_classes) > CLS) begin
            k_used = emw_pkg::NCLS_W'(CLS);
        end else begin
            k_used = cfg.num_classes;
        end
    end

    assign last_row = RW'(rows_used - RCW'(1));
    assign k_last   = emw_pkg::COL_W'(k_used - emw_pkg::NCLS_W'(1));
    assign col_end  = (r_col == k_last);

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_ov || o_out.ready;

    assign cur_addr  = {r_row, CW'(r_col)};
    assign lik_waddr = {RW'(i_in.row_addr), CW'(i_in.col_index)};
    assign lik_we    = in_acc && (i_in.op == emw_pkg::OP_LOAD)
                       && (32'(i_in.row_addr) < MAX_ROWS)
                       && (32'(i_in.col_index) < MAX_CLASSES);

    assign pst_we    = ((r_state == S_E_DIV) && (r_sum == '0))
                       || ((r_state == S_E_DIVW) && div_done);
    assign pst_wdata = (r_state == S_E_DIVW) ? div_q : '0;

    emw_ram #(.WIDTH(emw_pkg::LIK_W), .DEPTH(DEPTH)) u_lik_ram (
        .i_clk   (i_clk),
        .i_we    (lik_we),
        .i_waddr (lik_waddr),
        .i_wdata (i_in.likelihood),
        .i_raddr (cur_addr),
        .o_rdata (lik_rdata)
    );

    emw_ram #(.WIDTH(emw_pkg::VAL_W), .DEPTH(DEPTH)) u_pst_ram (
        .i_clk   (i_clk),
        .i_we    (pst_we),
        .i_waddr (cur_addr),
        .i_wdata (pst_wdata),
        .i_raddr (cur_addr),
        .o_rdata (pst_rdata)
    );

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (in_acc && (i_in.op == emw_pkg::OP_RUN)) begin
            div_start = 1'b1;
            div_num   = 64'h0000_0000_8000_0000;
            div_den   = emw_pkg::SUM_W'(k_used);
        end else if ((r_state == S_E_DIV) && (r_sum != '0)) begin
            div_start = 1'b1;
            div_num   = {1'b0, r_pbuf[r_col], 31'd0};
            div_den   = r_sum;
        end else if (r_state == S_M) begin
            div_start = 1'b1;
            div_num   = emw_pkg::NUM_W'(r_csum[r_col]);
            div_den   = emw_pkg::SUM_W'(rows_used);
        end
    end

    emw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ov      <= 1'b0;
            r_flag    <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
            r_iter    <= '0;
            r_allzero <= 1'b1;
            for (int j = 0; j < emw_pkg::NSLOT; j++) begin
                r_csum[j] <= '0;
            end
        end else begin
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (pst_we) begin
                if (col_end) begin
                    r_col <= '0;
                    if (r_row == last_row) begin
                        r_row <= '0;
                        if (r_iter != '0) begin
                            r_iter  <= r_iter - emw_pkg::ITER_W'(1);
                            r_state <= S_M;
                        end else begin
                            r_state <= S_EMIT_W;
                        end
                    end else begin
                        r_row   <= r_row + RW'(1);
                        r_sum   <= '0;
                        r_state <= S_E_RD;
                    end
                end else begin
                    r_col   <= r_col + emw_pkg::COL_W'(1);
                    r_state <= S_E_DIV;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in.op == emw_pkg::OP_RUN)) begin
                        r_flag  <= 1'b0;
                        r_state <= S_INIT;
                    end else if (in_acc && (i_in.op == emw_pkg::OP_READ)
                                 && (32'(i_in.row_addr) < MAX_ROWS)) begin
                        r_row     <= RW'(i_in.row_addr);
                        r_col     <= '0;
                        r_allzero <= 1'b1;
                        r_state   <= S_RD_RQ;
                    end
                end
                S_INIT: begin
                    if (div_done) begin
                        for (int j = 0; j < emw_pkg::NSLOT; j++) begin
                            r_w[j] <= (j < 32'(k_used)) ? div_q : '0;
                        end
                        r_iter  <= cfg.iterations;
                        r_state <= S_E_START;
                    end
                end
                S_E_START: begin
                    for (int j = 0; j < emw_pkg::NSLOT; j++) begin
                        r_csum[j] <= '0;
                    end
                    r_row   <= '0;
                    r_col   <= '0;
                    r_sum   <= '0;
                    r_state <= S_E_RD;
                end
                S_E_RD: begin
                    r_state <= S_E_MUL;
                end
                S_E_MUL: begin
                    r_mul   <= 64'(r_w[r_col]) * 64'(lik_rdata);
                    r_state <= S_E_ACC;
                end
                S_E_ACC: begin
                    r_pbuf[r_col] <= r_mul[63:32];
                    r_sum         <= r_sum + emw_pkg::SUM_W'(r_mul[63:32]);
                    if (col_end) begin
                        r_col   <= '0;
                        r_state <= S_E_DIV;
                    end else begin
                        r_col   <= r_col + emw_pkg::COL_W'(1);
                        r_state <= S_E_RD;
                    end
                end
                S_E_DIV: begin
                    if (r_sum == '0) begin
                        r_flag <= 1'b1;
                    end else begin
                        r_state <= S_E_DIVW;
                    end
                end
                S_E_DIVW: begin
                    if (div_done) begin
                        r_csum[r_col] <= r_csum[r_col] + emw_pkg::CSUM_W'(div_q);
                    end
                end
                S_M: begin
                    r_state <= S_MW;
                end
                S_MW: begin
                    if (div_done) begin
                        r_w[r_col] <= div_q;
                        if (col_end) begin
                            r_col   <= '0;
                            r_state <= S_E_START;
                        end else begin
                            r_col   <= r_col + emw_pkg::COL_W'(1);
                            r_state <= S_M;
                        end
                    end
                end
                S_EMIT_W: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_kind  <= emw_pkg::KIND_WEIGHT;
                        r_index <= r_col;
                        r_value <= r_w[r_col];
                        r_zrs   <= r_flag;
                        r_last  <= col_end;
                        if (col_end) begin
                            r_col   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_col <= r_col + emw_pkg::COL_W'(1);
                        end
                    end
                end
                S_RD_RQ: begin
                    r_state <= S_RD_DAT;
                end
                S_RD_DAT: begin
                    r_pbuf[r_col] <= pst_rdata;
                    if (pst_rdata != '0) begin
                        r_allzero <= 1'b0;
                    end
                    if (col_end) begin
                        r_col   <= '0;
                        r_state <= S_RD_EMIT;
                    end else begin
                        r_col   <= r_col + emw_pkg::COL_W'(1);
                        r_state <= S_RD_RQ;
                    end
                end
                S_RD_EMIT: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_kind  <= emw_pkg::KIND_POSTERIOR;
                        r_index <= r_col;
                        r_value <= r_pbuf[r_col];
                        r_zrs   <= r_allzero;
                        r_last  <= col_end;
                        if (col_end) begin
                            r_col   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_col <= r_col + emw_pkg::COL_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.kind          = r_kind;
    assign o_out.index         = r_index;
    assign o_out.value         = r_value;
    assign o_out.zero_row_seen = r_zrs;
    assign o_out.last          = r_last;

endmodule

// ----- sv/emw_ram.sv -----
module emw_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/emw_div.sv -----
module emw_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [emw_pkg::NUM_W-1:0]     i_num,
    input  logic [emw_pkg::SUM_W-1:0]     i_den,
    output logic                          o_done,
    output logic [emw_pkg::VAL_W-1:0]     o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [5:0]                    r_cnt;
    logic [emw_pkg::SUM_W-1:0]     r_rem;
    logic [emw_pkg::SUM_W-1:0]     r_den;
    logic [emw_pkg::VAL_W-1:0]     r_lo;
    logic [emw_pkg::SUM_W:0]       trial;
    logic                          fits;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_lo[emw_pkg::VAL_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_rem  <= emw_pkg::SUM_W'(i_num[63:32]);
                r_lo   <= i_num[31:0];
                r_den  <= i_den;
            end else if (r_busy) begin
                if (fits) begin
                    r_rem <= emw_pkg::SUM_W'(trial - {1'b0, r_den});
                end else begin
                    r_rem <= trial[emw_pkg::SUM_W-1:0];
                end
                r_lo  <= {r_lo[emw_pkg::VAL_W-2:0], fits};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_lo;

endmodule

// ----- sv/emw_cfg.sv -----
module emw_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [emw_pkg::PADDR_W-1:0]     paddr,
    input  logic [emw_pkg::PDATA_W-1:0]     pwdata,
    output logic [emw_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    output emw_pkg::t_cfg                   o_cfg
);

    emw_pkg::t_cfg r_cfg;
    logic [1:0]    reg_sel;

    assign reg_sel = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_rows    <= emw_pkg::NROWS_W'(1);
            r_cfg.num_classes <= emw_pkg::NCLS_W'(1);
            r_cfg.iterations  <= emw_pkg::ITER_W'(1);
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                emw_pkg::REG_NUM_ROWS: begin
                    r_cfg.num_rows <= pwdata[emw_pkg::NROWS_W-1:0];
                end
                emw_pkg::REG_NUM_CLASSES: begin
                    r_cfg.num_classes <= pwdata[emw_pkg::NCLS_W-1:0];
                end
                emw_pkg::REG_ITERATIONS: begin
                    r_cfg.iterations <= pwdata[emw_pkg::ITER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            emw_pkg::REG_NUM_ROWS:    prdata = emw_pkg::PDATA_W'(r_cfg.num_rows);
            emw_pkg::REG_NUM_CLASSES: prdata = emw_pkg::PDATA_W'(r_cfg.num_classes);
            emw_pkg::REG_ITERATIONS:  prdata = emw_pkg::PDATA_W'(r_cfg.iterations);
            default:                  prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

// ----- bench/emw_checker.sv -----
module emw_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    emw_in_if                               i_mon_in,
    emw_out_if                              i_mon_out,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [emw_pkg::PADDR_W-1:0]     i_paddr,
    input  logic [emw_pkg::PDATA_W-1:0]     i_pwdata,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_checked
);

    localparam int unsigned ROWS_MAX = 4096;
    localparam int unsigned CLS_MAX  = 16;

    typedef struct packed {
        logic                        kind;
        logic [emw_pkg::COL_W-1:0]   index;
        logic [emw_pkg::VAL_W-1:0]   value;
        logic                        zero_row_seen;
        logic                        last;
    } t_result;

    logic [emw_pkg::LIK_W-1:0] lik_mem  [0:ROWS_MAX*CLS_MAX-1];
    logic [emw_pkg::VAL_W-1:0] post_mem [0:ROWS_MAX*CLS_MAX-1];
    logic [emw_pkg::VAL_W-1:0] weight   [emw_pkg::NSLOT];
    logic                      zero_flag;
    emw_pkg::t_cfg             cfg;
    t_result                   expected_q[$];

    function automatic int rows_in_use();
        int r;
        r = cfg.num_rows;
        if (r < 1) r = 1;
        if (r > ROWS_MAX) r = ROWS_MAX;
        return r;
    endfunction

    function automatic int classes_in_use();
        int k;
        k = cfg.num_classes;
        if (k < 1) k = 1;
        if (k > CLS_MAX) k = CLS_MAX;
        return k;
    endfunction

    task automatic posterior_pass(input int r, input int k);
        logic [63:0] prod [emw_pkg::NSLOT];
        logic [63:0] sum;
        int base;
        for (int i = 0; i < r; i++) begin
            base = i * CLS_MAX;
            sum = '0;
            for (int j = 0; j < k; j++) begin
                prod[j] = ({32'd0, weight[j]} * {32'd0, lik_mem[base+j]}) >> 32;
                sum += prod[j];
            end
            for (int j = 0; j < k; j++) begin
                if (sum == 0) post_mem[base+j] = '0;
                else post_mem[base+j] = 32'((prod[j] << 31) / sum);
            end
            if (sum == 0) zero_flag = 1'b1;
        end
    endtask

    task automatic weight_pass(input int r, input int k);
        logic [63:0] col_sum;
        for (int j = 0; j < k; j++) begin
            col_sum = '0;
            for (int i = 0; i < r; i++) col_sum += post_mem[i*CLS_MAX+j];
            col_sum &= 64'hFFFF_FFFF_FFFF;
            weight[j] = 32'(col_sum / r);
        end
    endtask

    task automatic estimate_proportions();
        int r, k;
        t_result item;
        r = rows_in_use();
        k = classes_in_use();
        zero_flag = 1'b0;
        for (int j = 0; j < emw_pkg::NSLOT; j++)
            weight[j] = (j < k) ? 32'((64'd1 << 31) / k) : '0;
        for (int it = 0; it < cfg.iterations; it++) begin
            posterior_pass(r, k);
            weight_pass(r, k);
        end
        posterior_pass(r, k);
        for (int j = 0; j < k; j++) begin
            item = '{emw_pkg::KIND_WEIGHT, emw_pkg::COL_W'(j), weight[j], zero_flag,
                     j == k - 1};
            expected_q = {expected_q, item};
        end
    endtask

    task automatic read_row(input int row);
        int k;
        logic all_zero;
        t_result item;
        k = classes_in_use();
        all_zero = 1'b1;
        for (int j = 0; j < k; j++) if (post_mem[row*CLS_MAX+j] != 0) all_zero = 1'b0;
        for (int j = 0; j < k; j++) begin
            item = '{emw_pkg::KIND_POSTERIOR, emw_pkg::COL_W'(j), post_mem[row*CLS_MAX+j],
                     all_zero, j == k - 1};
            expected_q = {expected_q, item};
        end
    endtask

    function automatic int check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
        cfg = '{num_rows: 1, num_classes: 1, iterations: 1};
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        int bad;
        if (!i_rst_n) begin
            cfg = '{num_rows: 1, num_classes: 1, iterations: 1};
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    emw_pkg::REG_NUM_ROWS:
                        cfg.num_rows = i_pwdata[emw_pkg::NROWS_W-1:0];
                    emw_pkg::REG_NUM_CLASSES:
                        cfg.num_classes = i_pwdata[emw_pkg::NCLS_W-1:0];
                    emw_pkg::REG_ITERATIONS:
                        cfg.iterations = i_pwdata[emw_pkg::ITER_W-1:0];
                    default: ;
                endcase
            end
            if (i_mon_in.valid && i_mon_in.ready) begin
                case (i_mon_in.op)
                    emw_pkg::OP_LOAD:
                        lik_mem[i_mon_in.row_addr*CLS_MAX + i_mon_in.col_index] =
                            i_mon_in.likelihood;
                    emw_pkg::OP_RUN:  estimate_proportions();
                    emw_pkg::OP_READ: read_row(i_mon_in.row_addr);
                    default: ;
                endcase
            end
            if (i_mon_out.valid && i_mon_out.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    bad = check_field("kind", exp_r.kind, i_mon_out.kind)
                        + check_field("index", exp_r.index, i_mon_out.index)
                        + check_field("value", exp_r.value, i_mon_out.value)
                        + check_field("zero_row_seen", exp_r.zero_row_seen,
                                      i_mon_out.zero_row_seen)
                        + check_field("last", exp_r.last, i_mon_out.last);
                    if (bad != 0) o_errors <= o_errors + 1;
                    o_checked <= o_checked + 1;
                end
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;

    localparam logic [emw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [emw_pkg::PADDR_W-1:0] paddr;
    logic [emw_pkg::PDATA_W-1:0] pwdata;
    logic [emw_pkg::PDATA_W-1:0] prdata;
    logic pready;
    int errors, pending, checked;
    int cycles, burst_left, rx_cnt;
    int n_items, n_runs, n_reads, n_loads;
    int cur_rows, cur_classes;
    bit post_written [0:65535];

    emw_in_if  in_ch ();
    emw_out_if out_ch ();

    em_mixture_weight_estimation_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    emw_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mon_in  (in_ch),
        .i_mon_out (out_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_pready  (pready),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        rx_cnt <= rx_cnt + 1;
        case ((rx_cnt / 250) % 3)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic send_item(input logic [emw_pkg::OP_W-1:0] op, input int row, input int col,
                             input logic [emw_pkg::LIK_W-1:0] lik);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.row_addr   <= emw_pkg::ROW_W'(row);
        in_ch.col_index  <= emw_pkg::COL_W'(col);
        in_ch.likelihood <= lik;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        n_items++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= emw_pkg::PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic bus_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int r, input int k, input int it);
        settle();
        write_reg(emw_pkg::REG_NUM_ROWS, r);
        write_reg(emw_pkg::REG_NUM_CLASSES, k);
        write_reg(emw_pkg::REG_ITERATIONS, it);
        bus_idle();
        cur_rows    = (r < 1) ? 1 : ((r > 4096) ? 4096 : r);
        cur_classes = (k < 1) ? 1 : ((k > 16) ? 16 : k);
    endtask

    function automatic logic [emw_pkg::LIK_W-1:0] pick_likelihood();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return emw_pkg::LIK_W'($urandom_range(0, 3));
            2: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_matrix();
        bit zero_row;
        for (int i = 0; i < cur_rows; i++) begin
            zero_row = ($urandom_range(0, 5) == 0);
            for (int j = 0; j < cur_classes; j++) begin
                send_item(emw_pkg::OP_LOAD, i, j, zero_row ? '0 : pick_likelihood());
                n_loads++;
            end
        end
    endtask

    task automatic run_estimation();
        send_item(emw_pkg::OP_RUN, $urandom, $urandom, $urandom);
        n_runs++;
        for (int i = 0; i < cur_rows; i++)
            for (int j = 0; j < cur_classes; j++) post_written[i*16+j] = 1'b1;
    endtask

    function automatic bit row_readable(input int row);
        for (int j = 0; j < cur_classes; j++) if (!post_written[row*16+j]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic read_row(input int row);
        send_item(emw_pkg::OP_READ, row, $urandom, $urandom);
        n_reads++;
    endtask

    task automatic noise_items(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                send_item(OP_UNUSED, $urandom, $urandom, $urandom);
            end else begin
                send_item(emw_pkg::OP_LOAD, $urandom_range(0, 4095), $urandom_range(0, 15),
                          $urandom);
                n_loads++;
            end
        end
    endtask

    initial begin
        int row;
        cycles = 0; rx_cnt = 0; burst_left = 0;
        n_items = 0; n_runs = 0; n_reads = 0; n_loads = 0;
        cur_rows = 1; cur_classes = 1;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.op         <= emw_pkg::OP_LOAD;
        in_ch.row_addr   <= '0;
        in_ch.col_index  <= '0;
        in_ch.likelihood <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults, single element at full scale
        send_item(emw_pkg::OP_LOAD, 0, 0, '1);
        run_estimation();
        read_row(0);
        send_item(OP_UNUSED, 4095, 15, '1);

        // clamped low registers and a zero row
        configure(0, 0, 0);
        send_item(emw_pkg::OP_LOAD, 0, 0, '0);
        run_estimation();
        read_row(0);

        // full class count, rows with extremes and truncating products
        configure(3, 31, 2);
        for (int j = 0; j < 16; j++) begin
            send_item(emw_pkg::OP_LOAD, 0, j, (j % 2) ? 32'h8000_0000 : '1);
            send_item(emw_pkg::OP_LOAD, 1, j, 32'd1);
            send_item(emw_pkg::OP_LOAD, 2, j, (j == 15) ? '1 : '0);
            n_loads += 3;
        end
        run_estimation();
        for (int i = 0; i < 3; i++) read_row(i);

        // many iterations on a single element
        configure(1, 1, 1023);
        send_item(emw_pkg::OP_LOAD, 0, 0, 32'h1234_5678);
        run_estimation();

        while (n_items < 320) begin
            if ($urandom_range(0, 3) == 0)
                configure($urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(0, 4));
            else
                configure($urandom_range(1, 5), $urandom_range(1, 8), $urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0) noise_items($urandom_range(1, 6));
            load_matrix();
            if ($urandom_range(0, 3) == 0) noise_items($urandom_range(1, 4));
            run_estimation();
            for (int i = 0; i < $urandom_range(1, 4); i++) begin
                row = $urandom_range(0, 7);
                if (row_readable(row)) read_row(row);
            end
        end

        // largest row count, reads only
        configure(8191, 1, 0);
        for (int i = 0; i < 8; i++) if (row_readable(i)) read_row(i);

        settle();
        repeat (200) @(posedge i_clk);
        $display("covered %0d items: %0d loads, %0d runs, %0d reads", n_items, n_loads,
                 n_runs, n_reads);
        $display("result transactions checked: %0d", checked);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
